@@ rtl/dqs_pkg.sv @@
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types, sizes and codes for the double-ended queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WORD_W     = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 8;
  localparam int STATUS_W   = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_SEARCH     = 3'd3,
    KIND_READ_POS   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_ROTATE
  } state_t;

  typedef struct packed {
    cell_op_t         op;
    logic             load_front;
    logic             load_back;
    logic [IDX_W-1:0] back_idx;
  } chain_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              found;
    logic [CNT_W-1:0]  entry_count;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/dqs_cell.sv @@
// ----------------------------------------------------------------------------
// dqs_cell
// One storage cell of the queue chain: holds, loads, or takes a neighbor word.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_cell (
  input  wire logic               clk,
  input  wire dqs_pkg::cell_op_t  op,
  input  wire logic               load,
  input  wire dqs_pkg::word_t     load_word,
  input  wire dqs_pkg::word_t     prev_word,
  input  wire dqs_pkg::word_t     next_word,
  output      dqs_pkg::word_t     word
);

  dqs_pkg::word_t word_r;
  dqs_pkg::word_t word_nxt;

  always_comb begin
    if (load) begin
      word_nxt = load_word;
    end else begin
      case (op)
        dqs_pkg::CELL_TAKE_PREV: word_nxt = prev_word;
        dqs_pkg::CELL_TAKE_NEXT: word_nxt = next_word;
        default:                 word_nxt = word_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

@@ rtl/dqs_chain.sv @@
// ----------------------------------------------------------------------------
// dqs_chain
// Ring of storage cells; cell 0 always holds the front entry between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_chain (
  input  wire logic                  clk,
  input  wire dqs_pkg::chain_ctrl_t  ctrl,
  input  wire dqs_pkg::word_t        load_word,
  output      dqs_pkg::word_t        front_word
);

  dqs_pkg::word_t cells [dqs_pkg::DEPTH];

  for (genvar i = 0; i < dqs_pkg::DEPTH; i++) begin : g_cell
    localparam int PREV = (i + dqs_pkg::DEPTH - 1) % dqs_pkg::DEPTH;
    localparam int NEXT = (i + 1) % dqs_pkg::DEPTH;

    logic load;

    assign load = (ctrl.load_front && (i == 0)) ||
                  (ctrl.load_back && (ctrl.back_idx == dqs_pkg::IDX_W'(i)));

    dqs_cell u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .load      (load),
      .load_word (load_word),
      .prev_word (cells[PREV]),
      .next_word (cells[NEXT]),
      .word      (cells[i])
    );
  end

  assign front_word = cells[0];

endmodule

`default_nettype wire

@@ rtl/deque_with_search.sv @@
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue in a ring of cells, with search and indexed read.
// ----------------------------------------------------------------------------
//  channel   ports                                                   dir
//  in        in_valid in_stall in_kind in_data_word in_position      request
//  out       out_valid out_stall out_read_word out_found
//            out_entry_count out_status                              result
//
//  push front, push back, pop, empty search, error and unused requests give their result when accepted.
//  search and read rotate the whole cell ring once, as there is only the
//  single front compare and read port at cell 0.
//  reset empties the queue; cell contents are not cleared.
//  an output register plus one skid stage let one request run while a
//  result waits under out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_search (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [dqs_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [dqs_pkg::WORD_W-1:0]     in_data_word,
  input  wire logic [dqs_pkg::POS_W-1:0]      in_position,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [dqs_pkg::WORD_W-1:0]     out_read_word,
  output      logic                           out_found,
  output      logic [dqs_pkg::CNT_W-1:0]      out_entry_count,
  output      logic [dqs_pkg::STATUS_W-1:0]   out_status
);

  dqs_pkg::state_t             state_r, state_nxt;
  logic [dqs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [dqs_pkg::IDX_W-1:0]   step_r, step_nxt;
  logic                        hit_r, hit_nxt;
  dqs_pkg::word_t              rd_r, rd_nxt;
  dqs_pkg::word_t              key_r;
  logic [dqs_pkg::POS_W-1:0]   pos_r;
  logic                        search_r;

  dqs_pkg::chain_ctrl_t        ctrl;
  dqs_pkg::word_t              in_word;
  dqs_pkg::word_t              front_word;

  logic                        accept;
  logic                        res_valid;
  dqs_pkg::result_t            res;
  logic                        out_valid_r;
  dqs_pkg::result_t            out_r;
  logic                        skid_valid_r;
  dqs_pkg::result_t            skid_r;
  logic                        out_free;

  assign in_word  = in_data_word[dqs_pkg::DATA_WIDTH-1:0];
  assign in_stall = (state_r != dqs_pkg::ST_IDLE) || skid_valid_r;
  assign accept   = in_valid && !in_stall;

  dqs_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_word  (in_word),
    .front_word (front_word)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    hit_nxt       = hit_r;
    rd_nxt        = rd_r;
    ctrl.op         = dqs_pkg::CELL_HOLD;
    ctrl.load_front = 1'b0;
    ctrl.load_back  = 1'b0;
    ctrl.back_idx   = count_r[dqs_pkg::IDX_W-1:0];
    res_valid     = 1'b0;
    res           = '0;
    res.status    = dqs_pkg::STATUS_OK;
    unique case (state_r)
      dqs_pkg::ST_IDLE: begin
        step_nxt = '0;
        hit_nxt  = 1'b0;
        rd_nxt   = '0;
        if (accept) begin
          res_valid = 1'b1;
          case (in_kind)
            dqs_pkg::KIND_PUSH_FRONT: begin
              if (count_r == dqs_pkg::CNT_W'(dqs_pkg::DEPTH)) begin
                res.status = dqs_pkg::STATUS_FULL;
              end else begin
                ctrl.op         = dqs_pkg::CELL_TAKE_PREV;
                ctrl.load_front = 1'b1;
                count_nxt       = count_r + 1'b1;
              end
            end
            dqs_pkg::KIND_PUSH_BACK: begin
              if (count_r == dqs_pkg::CNT_W'(dqs_pkg::DEPTH)) begin
                res.status = dqs_pkg::STATUS_FULL;
              end else begin
                ctrl.load_back = 1'b1;
                count_nxt      = count_r + 1'b1;
              end
            end
            dqs_pkg::KIND_POP_FRONT: begin
              if (count_r == '0) begin
                res.status = dqs_pkg::STATUS_EMPTY;
              end else begin
                ctrl.op       = dqs_pkg::CELL_TAKE_NEXT;
                res.read_word = dqs_pkg::WORD_W'(front_word);
                count_nxt     = count_r - 1'b1;
              end
            end
            dqs_pkg::KIND_SEARCH: begin
              if (count_r != '0) begin
                res_valid = 1'b0;
                state_nxt = dqs_pkg::ST_ROTATE;
              end
            end
            dqs_pkg::KIND_READ_POS: begin
              if (32'(in_position) >= 32'(count_r)) begin
                res.status = dqs_pkg::STATUS_RANGE;
              end else begin
                res_valid = 1'b0;
                state_nxt = dqs_pkg::ST_ROTATE;
              end
            end
            default: begin
            end
          endcase
          res.entry_count = count_nxt;
        end
      end
      dqs_pkg::ST_ROTATE: begin
        ctrl.op  = dqs_pkg::CELL_TAKE_NEXT;
        step_nxt = step_r + 1'b1;
        if (search_r && (32'(step_r) < 32'(count_r)) && (front_word == key_r)) begin
          hit_nxt = 1'b1;
        end
        if (!search_r && (32'(step_r) == 32'(pos_r))) begin
          rd_nxt = front_word;
        end
        if (step_r == dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1)) begin
          state_nxt       = dqs_pkg::ST_IDLE;
          res_valid       = 1'b1;
          res.found       = hit_nxt;
          res.read_word   = dqs_pkg::WORD_W'(rd_nxt);
          res.entry_count = count_r;
        end
      end
      default: begin
        state_nxt = dqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqs_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    hit_r  <= hit_nxt;
    rd_r   <= rd_nxt;
    if (accept) begin
      key_r    <= in_word;
      pos_r    <= in_position;
      search_r <= (in_kind == dqs_pkg::KIND_SEARCH);
    end
  end

  // output register with one skid stage
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_word   = out_r.read_word;
  assign out_found       = out_r.found;
  assign out_entry_count = out_r.entry_count;
  assign out_status      = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dqs_pkg::CNT_W'(dqs_pkg::DEPTH))
    else $error("entry count above depth");

  a_rotate_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dqs_pkg::ST_ROTATE) |-> (in_stall && !res_valid ||
      step_r == dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1)))
    else $error("result or request taken during rotation");

  a_rotate_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dqs_pkg::ST_ROTATE && step_r == dqs_pkg::IDX_W'(dqs_pkg::DEPTH - 1))
      |=> (state_r == dqs_pkg::ST_IDLE && $past(res_valid)))
    else $error("rotation did not finish after one full turn");

endmodule

`default_nettype wire
